@@ rtl/ecpr_pkg.sv @@
// Shared types and constants for the enhanced clock page replacement block.
// No dependencies.
package ecpr_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_HIT,
      ST_SCAN,
      ST_EV_RD,
      ST_EV_WR
   } state_type;

   // Victim search passes; bit 0 is the wanted modify bit and the clear-passed flag.
   typedef logic [1:0] pass_type;
   localparam pass_type PASS_CLEAN   = 2'd0;
   localparam pass_type PASS_DIRTY   = 2'd1;
   localparam pass_type PASS_CLEAN_2 = 2'd2;
   localparam pass_type PASS_DIRTY_2 = 2'd3;

endpackage

@@ rtl/ecpr_if.sv @@
// Valid/ready channel interfaces for page references and replacement results.
// No dependencies.
interface ecpr_req_if #(
   parameter int PAGE_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;
   logic                 func;

   modport source (output valid, output page_number, output func, input ready);
   modport sink   (input valid, input page_number, input func, output ready);
endinterface

interface ecpr_rsp_if #(
   parameter int PAGE_BITS = 16,
   parameter int IDX_BITS  = 2
);
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [IDX_BITS-1:0]  frame_index;
   logic                 evicted_valid;
   logic [PAGE_BITS-1:0] evicted_page;
   logic                 evicted_dirty;
   logic [IDX_BITS-1:0]  hand_position;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output evicted_dirty, output hand_position,
                   input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input evicted_dirty, input hand_position,
                   output ready);
endinterface

@@ rtl/ecpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ecpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/enhanced_clock_page_replacement.sv @@
// Enhanced second-chance clock page replacement over a ring of frames.
// Depends on ecpr_pkg, ecpr_if (ecpr_req_if, ecpr_rsp_if) and ecpr_ram.
//
// Usage:
//   req_chan carries one page reference (page_number, func: 0 read, 1 write).
//   rsp_chan returns one result per reference: hit, frame_index, evicted_valid,
//   evicted_page, evicted_dirty and the new hand_position.
//   A transfer happens on a rising clock edge with valid and ready both high.
//   One reference is worked on at a time; req_chan.ready is high only while idle.
//   The page numbers sit in a small RAM read one frame per cycle; the lookup
//   compares one frame per cycle and the victim search checks one frame per
//   cycle over up to four passes round the ring.
//   The result sits in an output register, so a new request is taken while
//   the previous result still waits; if the receiver stalls, the next result
//   is held internally until the output register frees up.
//   Reset (synchronous, active high) empties every frame, clears the use and
//   modify bits and puts the hand at frame 0.
module enhanced_clock_page_replacement #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   ecpr_req_if.sink  req_chan,
   ecpr_rsp_if.source rsp_chan
);
   import ecpr_pkg::*;

   localparam int IDX_BITS = $clog2(FRAMES);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAMES - 1);

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   hand_ff, hand_in;
   logic [IDX_BITS-1:0]   ptr_ff, ptr_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   cmp_ptr_ff, cmp_ptr_in;
   logic                  cmp_en_ff, cmp_en_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_BITS-1:0]   victim_ff, victim_in;
   pass_type              pass_ff, pass_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic                  func_ff, func_in;
   logic [FRAMES-1:0]     valid_ff, valid_in;
   logic [FRAMES-1:0]     use_ff, use_in;
   logic [FRAMES-1:0]     dirty_ff, dirty_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IDX_BITS-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_BITS-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic                  rsp_ev_dirty_ff, rsp_ev_dirty_in;
   logic [IDX_BITS-1:0]   rsp_hand_ff, rsp_hand_in;

   logic                  req_xfer;
   logic                  out_free;
   logic [IDX_BITS-1:0]   ptr_nx;
   logic [IDX_BITS-1:0]   victim_nx;
   logic                  cnt_last;
   logic                  cmp_hit;
   logic                  scan_take;

   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [PAGE_BITS-1:0]  ram_rd_data;

   ecpr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (victim_ff),
      .wr_data (page_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ptr_nx    = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   assign victim_nx = (victim_ff == LAST_IDX) ? '0 : victim_ff + 1'b1;
   assign cnt_last  = (cnt_ff == LAST_IDX);
   assign cmp_hit   = cmp_en_ff && valid_ff[cmp_ptr_ff] && (ram_rd_data == page_ff);
   assign scan_take = !use_ff[ptr_ff] && (dirty_ff[ptr_ff] == pass_ff[0]);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer  = req_chan.valid && req_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (cmp_hit) begin
               state_in = ST_HIT;
            end else if (cmp_en_ff && cnt_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_take || (cnt_last && pass_ff == PASS_DIRTY_2)) state_in = ST_EV_RD;
         end
         ST_EV_RD: state_in = ST_EV_WR;
         ST_EV_WR: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_HIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and RAM control
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      ram_wr_en      = (state_ff == ST_EV_WR) && out_free;
      case (state_ff)
         ST_LOOK:  ram_rd_addr = ptr_ff;
         ST_EV_RD: ram_rd_addr = victim_ff;
         ST_EV_WR: ram_rd_addr = victim_ff;
         default:  ram_rd_addr = ptr_ff;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame_index   = rsp_idx_ff;
   assign rsp_chan.evicted_valid = rsp_ev_valid_ff;
   assign rsp_chan.evicted_page  = rsp_ev_page_ff;
   assign rsp_chan.evicted_dirty = rsp_ev_dirty_ff;
   assign rsp_chan.hand_position = rsp_hand_ff;

   // Datapath next values
   always_comb begin
      hand_in         = hand_ff;
      ptr_in          = ptr_ff;
      cnt_in          = cnt_ff;
      cmp_ptr_in      = cmp_ptr_ff;
      cmp_en_in       = cmp_en_ff;
      hit_idx_in      = hit_idx_ff;
      victim_in       = victim_ff;
      pass_in         = pass_ff;
      page_in         = page_ff;
      func_in         = func_ff;
      valid_in        = valid_ff;
      use_in          = use_ff;
      dirty_in        = dirty_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_idx_in      = rsp_idx_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_ev_dirty_in = rsp_ev_dirty_ff;
      rsp_hand_in     = rsp_hand_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               page_in   = req_chan.page_number;
               func_in   = req_chan.func;
               ptr_in    = hand_ff;
               cnt_in    = '0;
               cmp_en_in = 1'b0;
            end
         end
         ST_LOOK: begin
            ptr_in     = ptr_nx;
            cmp_ptr_in = ptr_ff;
            cmp_en_in  = 1'b1;
            if (cmp_en_ff) begin
               if (cmp_hit) begin
                  hit_idx_in = cmp_ptr_ff;
               end else if (cnt_last) begin
                  cnt_in  = '0;
                  ptr_in  = hand_ff;
                  pass_in = PASS_CLEAN;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (scan_take) begin
               victim_in = ptr_ff;
            end else begin
               if (pass_ff[0]) use_in[ptr_ff] = 1'b0;
               if (cnt_last) begin
                  if (pass_ff == PASS_DIRTY_2) begin
                     victim_in = hand_ff;
                  end else begin
                     pass_in = pass_ff + 2'd1;
                     ptr_in  = hand_ff;
                     cnt_in  = '0;
                     if (pass_ff == PASS_DIRTY) use_in = '0;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  ptr_in = ptr_nx;
               end
            end
         end
         ST_HIT: begin
            if (out_free) begin
               use_in[hit_idx_ff] = 1'b1;
               if (func_ff) dirty_in[hit_idx_ff] = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = 1'b1;
               rsp_idx_in      = hit_idx_ff;
               rsp_ev_valid_in = 1'b0;
               rsp_ev_page_in  = '0;
               rsp_ev_dirty_in = 1'b0;
               rsp_hand_in     = hand_ff;
            end
         end
         ST_EV_WR: begin
            if (out_free) begin
               valid_in[victim_ff] = 1'b1;
               use_in[victim_ff]   = 1'b1;
               dirty_in[victim_ff] = func_ff;
               hand_in             = victim_nx;
               rsp_valid_in        = 1'b1;
               rsp_hit_in          = 1'b0;
               rsp_idx_in          = victim_ff;
               rsp_ev_valid_in     = valid_ff[victim_ff];
               rsp_ev_page_in      = valid_ff[victim_ff] ? ram_rd_data : '0;
               rsp_ev_dirty_in     = valid_ff[victim_ff] && dirty_ff[victim_ff];
               rsp_hand_in         = victim_nx;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         cmp_en_ff    <= 1'b0;
         valid_ff     <= '0;
         use_ff       <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         cmp_en_ff    <= cmp_en_in;
         valid_ff     <= valid_in;
         use_ff       <= use_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      cnt_ff          <= cnt_in;
      cmp_ptr_ff      <= cmp_ptr_in;
      hit_idx_ff      <= hit_idx_in;
      victim_ff       <= victim_in;
      pass_ff         <= pass_in;
      page_ff         <= page_in;
      func_ff         <= func_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_idx_ff      <= rsp_idx_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_ev_dirty_ff <= rsp_ev_dirty_in;
      rsp_hand_ff     <= rsp_hand_in;
   end

   // The hand moves only when a miss is committed.
   a_hand_hold: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_EV_WR && out_free) |=> $stable(hand_ff))
      else $error("hand moved outside a miss commit");

   // A committed hit leaves the frame's use bit set.
   a_hit_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HIT && out_free) |=> use_ff[$past(hit_idx_ff)])
      else $error("use bit not set after hit");

   // A committed miss leaves the victim frame valid and referenced.
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV_WR && out_free) |=> (valid_ff[$past(victim_ff)] &&
                                             use_ff[$past(victim_ff)]))
      else $error("victim frame not filled");

   // A result appears only from a commit state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HIT || $past(state_ff) == ST_EV_WR))
      else $error("result without commit");

endmodule
